### sv/htw_pkg.sv
// Package with shared types and codes for the hashed timing wheel.
`timescale 1ns / 1ps
package htw_pkg;
	localparam int NUM_SLOTS = 64;
	localparam int NUM_TIMERS = 32;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_DEL = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	localparam logic [2:0] KIND_ADDED = 3'd0;
	localparam logic [2:0] KIND_ZERO = 3'd1;
	localparam logic [2:0] KIND_FULL = 3'd2;
	localparam logic [2:0] KIND_DELETED = 3'd3;
	localparam logic [2:0] KIND_NOTFOUND = 3'd4;
	localparam logic [2:0] KIND_EXPIRED = 3'd5;
	localparam logic [2:0] KIND_TICKDONE = 3'd6;

	typedef struct packed {
		logic load;
		logic rd_add;
		logic rd_del;
		logic rd_tick;
		logic add_commit;
		logic unlink;
		logic step;
		logic decr;
		logic tick_done;
		logic emit;
		logic [2:0] kind;
		logic emit_id;
		logic last;
	} htw_cmd_t;

	typedef struct packed {
		logic zero_to;
		logic pool_full;
		logic del_bad;
		logic walk_end;
		logic del_hit;
		logic tick_expire;
	} htw_sts_t;
endpackage

### sv/htw_ctrl.sv
// Controller state machine that sequences add, delete and tick items.
`timescale 1ns / 1ps
module htw_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] action,
	input htw_pkg::htw_sts_t sts,
	output logic busy,
	output htw_pkg::htw_cmd_t cmd
);
	import htw_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_ADD_RD = 8'b00000010,
		ST_ADD = 8'b00000100,
		ST_DEL_RD = 8'b00001000,
		ST_DEL = 8'b00010000,
		ST_TICK_RD = 8'b00100000,
		ST_TICK = 8'b01000000,
		ST_DONE = 8'b10000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (action)
						ACT_ADD: state_d = ST_ADD_RD;
						ACT_DEL: state_d = ST_DEL_RD;
						ACT_TICK: state_d = ST_TICK_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD: begin
				cmd.rd_add = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
				state_d = ST_IDLE;
				if (sts.zero_to) begin
					cmd.kind = KIND_ZERO;
				end else if (sts.pool_full) begin
					cmd.kind = KIND_FULL;
				end else begin
					cmd.kind = KIND_ADDED;
					cmd.emit_id = 1'b1;
					cmd.add_commit = 1'b1;
				end
			end
			ST_DEL_RD: begin
				cmd.rd_del = 1'b1;
				if (sts.del_bad) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					cmd.kind = KIND_NOTFOUND;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DEL;
				end
			end
			ST_DEL: begin
				if (sts.walk_end) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					cmd.kind = KIND_NOTFOUND;
					state_d = ST_IDLE;
				end else if (sts.del_hit) begin
					cmd.unlink = 1'b1;
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					cmd.kind = KIND_DELETED;
					cmd.emit_id = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_TICK_RD: begin
				cmd.rd_tick = 1'b1;
				state_d = ST_TICK;
			end
			ST_TICK: begin
				if (sts.walk_end) begin
					state_d = ST_DONE;
				end else if (sts.tick_expire) begin
					cmd.unlink = 1'b1;
					cmd.emit = 1'b1;
					cmd.kind = KIND_EXPIRED;
					cmd.emit_id = 1'b1;
				end else begin
					cmd.step = 1'b1;
					cmd.decr = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.tick_done = 1'b1;
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
				cmd.kind = KIND_TICKDONE;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> busy) else $error("result outside an item");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> !busy) else $error("last without return to idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy) else $error("load while busy");
`endif
endmodule

### sv/htw_dp.sv
// Datapath with timer entries, slot lists, walk pointers and result registers.
`timescale 1ns / 1ps
module htw_dp (
	input logic clk,
	input logic arst_n,
	input logic [31:0] timeout,
	input logic [4:0] handle,
	input htw_pkg::htw_cmd_t cmd,
	output htw_pkg::htw_sts_t sts,
	output logic valid,
	output logic [2:0] kind,
	output logic [4:0] timer_id,
	output logic last
);
	import htw_pkg::*;

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int IW = $clog2(NUM_TIMERS);
	localparam int PW = IW + 1;
	localparam int RW = 32 - SW;
	localparam logic [PW-1:0] NONE = PW'(NUM_TIMERS);

	logic [NUM_TIMERS-1:0] valid_q;
	logic [SW-1:0] eslot_q [NUM_TIMERS];
	logic [RW-1:0] rot_q [NUM_TIMERS];
	logic [PW-1:0] next_q [NUM_TIMERS];
	logic [NUM_SLOTS-1:0] occ_q;
	logic [PW-1:0] head_q [NUM_SLOTS];
	logic [PW-1:0] tail_q [NUM_SLOTS];
	logic [SW-1:0] cur_slot_q;

	logic [31:0] to_q;
	logic [4:0] hdl_q;
	logic [SW-1:0] ws_q;
	logic [PW-1:0] prev_q, walk_q, tail_rd_q;
	logic [IW-1:0] free_e;
	logic full;
	logic [SW-1:0] add_s;
	logic [SW-1:0] del_slot;
	logic [SW-1:0] rd_slot;
	logic [PW-1:0] wnext;
	logic hdl_ok;

	always_comb begin
		free_e = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_e = IW'(i);
			end
		end
	end
	assign full = &valid_q;
	assign add_s = cur_slot_q + to_q[SW-1:0];
	assign hdl_ok = valid_q[hdl_q];
	assign del_slot = hdl_ok ? eslot_q[hdl_q] : cur_slot_q;
	assign wnext = next_q[walk_q[IW-1:0]];

	always_comb begin
		rd_slot = cur_slot_q;
		if (cmd.rd_add) begin
			rd_slot = add_s;
		end else if (cmd.rd_del) begin
			rd_slot = del_slot;
		end
	end

	assign sts.zero_to = (to_q == '0);
	assign sts.pool_full = full;
	assign sts.del_bad = !hdl_ok;
	assign sts.walk_end = (walk_q == NONE);
	assign sts.del_hit = (walk_q == {1'b0, hdl_q});
	assign sts.tick_expire = (walk_q != NONE) && (rot_q[walk_q[IW-1:0]] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q <= '0;
			cur_slot_q <= '0;
			valid <= 1'b0;
		end else begin
			valid <= cmd.emit;
			if (cmd.add_commit) begin
				valid_q[free_e] <= 1'b1;
				occ_q[ws_q] <= 1'b1;
			end
			if (cmd.unlink) begin
				valid_q[walk_q[IW-1:0]] <= 1'b0;
			end
			if (cmd.tick_done) begin
				cur_slot_q <= cur_slot_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		kind <= cmd.kind;
		last <= cmd.last;
		if (cmd.emit_id) begin
			timer_id <= cmd.add_commit ? free_e : walk_q[IW-1:0];
		end else begin
			timer_id <= '0;
		end
		if (cmd.load) begin
			to_q <= timeout;
			hdl_q <= handle;
		end
		if (cmd.rd_add || cmd.rd_del || cmd.rd_tick) begin
			ws_q <= rd_slot;
			prev_q <= NONE;
			walk_q <= occ_q[rd_slot] ? head_q[rd_slot] : NONE;
			tail_rd_q <= occ_q[rd_slot] ? tail_q[rd_slot] : NONE;
		end
		if (cmd.rd_add && !full) begin
			next_q[free_e] <= NONE;
		end
		if (cmd.add_commit) begin
			eslot_q[free_e] <= ws_q;
			rot_q[free_e] <= to_q[31:SW];
			tail_q[ws_q] <= {1'b0, free_e};
			if (tail_rd_q == NONE) begin
				head_q[ws_q] <= {1'b0, free_e};
			end else begin
				next_q[tail_rd_q[IW-1:0]] <= {1'b0, free_e};
			end
		end
		if (cmd.unlink) begin
			if (prev_q == NONE) begin
				head_q[ws_q] <= wnext;
			end else begin
				next_q[prev_q[IW-1:0]] <= wnext;
			end
			if (tail_rd_q == walk_q) begin
				tail_q[ws_q] <= prev_q;
				tail_rd_q <= prev_q;
			end
			walk_q <= wnext;
		end
		if (cmd.step) begin
			prev_q <= walk_q;
			walk_q <= wnext;
		end
		if (cmd.decr) begin
			rot_q[walk_q[IW-1:0]] <= rot_q[walk_q[IW-1:0]] - RW'(1);
		end
	end

`ifndef SYNTHESIS
	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_done |=> cur_slot_q == $past(cur_slot_q) + SW'(1))
		else $error("slot did not advance");
	a_add_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_commit |-> !full) else $error("add into full pool");
	a_unlink_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unlink |-> valid_q[walk_q[IW-1:0]]) else $error("unlink of free entry");
`endif
endmodule

### sv/hashed_timing_wheel_top.sv
// Top level of the hashed timing wheel: controller plus datapath.
`timescale 1ns / 1ps
// Usage: drive action, timeout and handle with start high; the item is taken
// at the rising edge where start is high and busy is low, and busy stays high
// until the controller has produced the item's final result.
// Results appear on kind, timer_id and last for one cycle each, marked by
// valid, in the cycle after the controller produces them; the receiver cannot
// stall them, so each result must be taken as it comes.
// Add: ST_ADD_RD reads the target slot list, then ST_ADD gives the result.
// Delete: ST_DEL_RD fetches the slot list head and answers a bad handle,
// then ST_DEL walks the list up to and including the match, or to its end.
// Tick: ST_TICK_RD fetches the slot list, ST_TICK walks it with each expired
// entry giving a result, and after the list end ST_DONE gives tick-done.
// The slot list walk, one entry a cycle, sets the item time; a new item
// can be taken in the cycle that carries the previous item's final result.
// After reset the pool is empty, every slot list is empty and the current
// slot is zero; per-slot occupancy bits stand in for a clearing pass.
// An unused action code is taken and returns no result.
module hashed_timing_wheel_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic [31:0] timeout,
	input logic [4:0] handle,
	output logic valid,
	output logic [2:0] kind,
	output logic [4:0] timer_id,
	output logic last
);
	import htw_pkg::*;

	htw_cmd_t cmd;
	htw_sts_t sts;

	htw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	htw_dp u_dp (
		.clk(clk), .arst_n(arst_n), .timeout(timeout), .handle(handle),
		.cmd(cmd), .sts(sts), .valid(valid), .kind(kind),
		.timer_id(timer_id), .last(last)
	);
endmodule
